// ----- sv/hslrgb_pkg.sv -----
// hslrgb_pkg: shared types, constants and helpers for the HSL to RGB converter.
// Used by every module of hsl_to_rgb_fixed and its checker.
package hslrgb_pkg;

  localparam int VAL_W  = 10;   // hue, saturation, lightness, levels
  localparam int CH_W   = 8;    // colour channel
  localparam int PROD_W = 20;   // products below 2^20
  localparam int OFF_W  = 12;   // signed shifted hue
  localparam int RCP_W  = 21;
  localparam int MUL_W  = PROD_W + RCP_W;
  localparam int SCL_W  = 29;
  localparam int OUTM_W = VAL_W + SCL_W;
  localparam int RCP_SH = 30;
  localparam int LATENCY = 9;

  localparam logic [VAL_W-1:0] FULL_SCALE = VAL_W'(1000);
  localparam logic [VAL_W-1:0] HALF_SCALE = VAL_W'(500);
  localparam logic [VAL_W-1:0] TWO_THIRDS = VAL_W'(2000 / 3);

  // ceil(2^30 / 1000): exact floor(x / 1000) for x below 6e6
  localparam logic [RCP_W-1:0] RECIP_1000 = RCP_W'(1073742);
  // 255 * RECIP_1000: floor(255 * x / 1000) in one product
  localparam logic [SCL_W-1:0] SCALE_255  = SCL_W'(255 * 1073742);

  localparam logic signed [OFF_W-1:0] OFF_RED   = OFF_W'(1000 / 3);
  localparam logic signed [OFF_W-1:0] OFF_GREEN = OFF_W'(0);
  localparam logic signed [OFF_W-1:0] OFF_BLUE  = -OFF_W'(1000 / 3);

  typedef enum logic [1:0] {
    SEG_UP,
    SEG_HIGH,
    SEG_DOWN,
    SEG_LOW
  } seg_t;

  typedef struct packed {
    seg_t             seg;
    logic [VAL_W-1:0] k;    // ramp weight, scaled by 1000
  } hue_t;

  typedef struct packed {
    logic [VAL_W-1:0] hi;
    logic [VAL_W-1:0] lo;
    logic [VAL_W-1:0] d;
  } lvl_t;

  function automatic logic [VAL_W-1:0] clamp_val(input logic [VAL_W-1:0] v);
    return (v > FULL_SCALE) ? FULL_SCALE : v;
  endfunction

endpackage

// ----- sv/hslrgb_hue.sv -----
// hslrgb_hue: hue shift, wrap and segment decode for one channel.
// Combinational; depends on hslrgb_pkg.
module hslrgb_hue import hslrgb_pkg::*; (
  input  logic [VAL_W-1:0]        hue,
  input  logic signed [OFF_W-1:0] offset,
  output hue_t                    hue_info
);

  logic signed [OFF_W-1:0] hs;
  logic signed [OFF_W-1:0] hw;
  logic [VAL_W-1:0]        hv;
  logic [OFF_W:0]          k_full;

  always_comb begin
    hs = $signed({2'b00, hue}) + offset;
    if (hs < 0) begin
      hw = hs + $signed({2'b00, FULL_SCALE});
    end else if (hs > $signed({2'b00, FULL_SCALE})) begin
      hw = hs - $signed({2'b00, FULL_SCALE});
    end else begin
      hw = hs;
    end
    hv = hw[VAL_W-1:0];

    k_full = '0;
    if (hv inside {[10'd0 : 10'd166]}) begin
      hue_info.seg = SEG_UP;
      k_full = (OFF_W+1)'(hv) * (OFF_W+1)'(6);
    end else if (hv inside {[10'd167 : 10'd499]}) begin
      hue_info.seg = SEG_HIGH;
    end else if (hv inside {[10'd500 : 10'd666]}) begin
      hue_info.seg = SEG_DOWN;
      k_full = (OFF_W+1)'(TWO_THIRDS - hv) * (OFF_W+1)'(6);
    end else begin
      hue_info.seg = SEG_LOW;
    end
    hue_info.k = k_full[VAL_W-1:0];
  end

endmodule

// ----- sv/hslrgb_levels.sv -----
// hslrgb_levels: three-stage pipeline forming the high and low levels.
// Depends on hslrgb_pkg.
module hslrgb_levels import hslrgb_pkg::*; (
  input  logic             clk,
  input  logic [VAL_W-1:0] sat,
  input  logic [VAL_W-1:0] light,
  output lvl_t             lvl
);

  logic [VAL_W:0]    op_a;
  logic [PROD_W-1:0] p_r, p_nxt;
  logic [MUL_W-1:0]  m_r, m_nxt;
  logic [VAL_W-1:0]  l1_r, s1_r, l2_r, s2_r;
  logic              lb1_r, lb1_nxt, lb2_r;
  logic [VAL_W-1:0]  q;
  logic [VAL_W:0]    sum;
  logic [VAL_W:0]    lo_full;
  lvl_t              lvl_r, lvl_nxt;

  // stage 1: l*(1000+s) below half scale, s*l at or above
  always_comb begin
    lb1_nxt = (light < HALF_SCALE);
    op_a    = lb1_nxt ? ({1'b0, sat} + {1'b0, FULL_SCALE}) : {1'b0, sat};
    p_nxt   = PROD_W'((2*VAL_W+1)'(light) * (2*VAL_W+1)'(op_a));
  end

  // stage 2: divide by 1000 through the reciprocal
  assign m_nxt = MUL_W'(p_r) * MUL_W'(RECIP_1000);

  // stage 3: levels
  always_comb begin
    q           = m_r[RCP_SH+VAL_W-1:RCP_SH];
    sum         = {1'b0, l2_r} + {1'b0, s2_r} - {1'b0, q};
    lvl_nxt.hi  = lb2_r ? q : sum[VAL_W-1:0];
    lo_full     = {l2_r, 1'b0} - {1'b0, lvl_nxt.hi};
    lvl_nxt.lo  = lo_full[VAL_W-1:0];
    lvl_nxt.d   = lvl_nxt.hi - lvl_nxt.lo;
  end

  always_ff @(posedge clk) begin
    p_r   <= p_nxt;
    l1_r  <= light;
    s1_r  <= sat;
    lb1_r <= lb1_nxt;
    m_r   <= m_nxt;
    l2_r  <= l1_r;
    s2_r  <= s1_r;
    lb2_r <= lb1_r;
    lvl_r <= lvl_nxt;
  end

  assign lvl = lvl_r;

endmodule

// ----- sv/hslrgb_chan.sv -----
// hslrgb_chan: per-channel pipeline, hue ramp and 255/1000 scaling.
// Depends on hslrgb_pkg; takes levels from hslrgb_levels.
module hslrgb_chan import hslrgb_pkg::*; (
  input  logic            clk,
  input  hue_t            hue_info,
  input  lvl_t            lvl,
  output logic [CH_W-1:0] color
);

  hue_t              h2_r, h3_r, h4_r, h5_r, h6_r;
  lvl_t              v5_r, v6_r;
  logic [PROD_W-1:0] pc_r, pc_nxt;
  logic [MUL_W-1:0]  mc_r, mc_nxt;
  logic [VAL_W-1:0]  q;
  logic [VAL_W:0]    ramp;
  logic [VAL_W-1:0]  level_r, level_nxt;
  logic [OUTM_W-1:0] ml_r, ml_nxt;
  logic [CH_W-1:0]   color_r;

  assign pc_nxt = PROD_W'(PROD_W'(lvl.d) * PROD_W'(h4_r.k));
  assign mc_nxt = MUL_W'(pc_r) * MUL_W'(RECIP_1000);

  always_comb begin
    q    = mc_r[RCP_SH+VAL_W-1:RCP_SH];
    ramp = {1'b0, v6_r.lo} + {1'b0, q};
    case (h6_r.seg)
      SEG_UP, SEG_DOWN: level_nxt = ramp[VAL_W-1:0];
      SEG_HIGH:         level_nxt = v6_r.hi;
      default:          level_nxt = v6_r.lo;
    endcase
  end

  assign ml_nxt = OUTM_W'(level_r) * OUTM_W'(SCALE_255);

  always_ff @(posedge clk) begin
    h2_r    <= hue_info;
    h3_r    <= h2_r;
    h4_r    <= h3_r;
    h5_r    <= h4_r;
    h6_r    <= h5_r;
    v5_r    <= lvl;
    v6_r    <= v5_r;
    pc_r    <= pc_nxt;
    mc_r    <= mc_nxt;
    level_r <= level_nxt;
    ml_r    <= ml_nxt;
    color_r <= ml_r[RCP_SH+CH_W-1:RCP_SH];
  end

  assign color = color_r;

endmodule

// ----- sv/hsl_to_rgb_fixed.sv -----
// hsl_to_rgb_fixed: top level, HSL (scaled by 1000) to 8-bit RGB pixel converter.
// Depends on hslrgb_pkg, hslrgb_hue, hslrgb_levels and hslrgb_chan.
//
//   channel  | ports                                   | handshake
//   ---------+-----------------------------------------+------------------------
//   input    | in_hue, in_saturation, in_lightness     | start && !busy
//   result   | out_red, out_green, out_blue            | out_valid, one cycle
//
// One item per clock; busy is never raised. Each result passes the input register,
// three level stages, then five channel stages (ramp product, divide, level, scale,
// out) before it reaches the ports together with out_valid.
// Synchronous reset clears the valid bits only; data registers are left.
// The receiver cannot stall, so the pipeline never holds.
module hsl_to_rgb_fixed import hslrgb_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [VAL_W-1:0] in_hue,
  input  logic [VAL_W-1:0] in_saturation,
  input  logic [VAL_W-1:0] in_lightness,
  output logic             out_valid,
  output logic [CH_W-1:0]  out_red,
  output logic [CH_W-1:0]  out_green,
  output logic [CH_W-1:0]  out_blue
);

  logic [LATENCY-1:0] vld_r, vld_nxt;
  logic [VAL_W-1:0]   h_r, s_r, l_r;
  hue_t               hue_red, hue_green, hue_blue;
  lvl_t               lvl;

  assign busy    = 1'b0;
  assign vld_nxt = {vld_r[LATENCY-2:0], start & ~busy};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    h_r <= clamp_val(in_hue);
    s_r <= clamp_val(in_saturation);
    l_r <= clamp_val(in_lightness);
  end

  hslrgb_hue u_hue_red   (.hue(h_r), .offset(OFF_RED),   .hue_info(hue_red));
  hslrgb_hue u_hue_green (.hue(h_r), .offset(OFF_GREEN), .hue_info(hue_green));
  hslrgb_hue u_hue_blue  (.hue(h_r), .offset(OFF_BLUE),  .hue_info(hue_blue));

  hslrgb_levels u_levels (.clk(clk), .sat(s_r), .light(l_r), .lvl(lvl));

  hslrgb_chan u_red   (.clk(clk), .hue_info(hue_red),   .lvl(lvl), .color(out_red));
  hslrgb_chan u_green (.clk(clk), .hue_info(hue_green), .lvl(lvl), .color(out_green));
  hslrgb_chan u_blue  (.clk(clk), .hue_info(hue_blue),  .lvl(lvl), .color(out_blue));

  assign out_valid = vld_r[LATENCY-1];

endmodule

// ----- sv/hslrgb_chk.sv -----
// hslrgb_chk: port-level checks for hsl_to_rgb_fixed, bound to the top level.
// Depends on hslrgb_pkg.
module hslrgb_chk import hslrgb_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             start,
  input logic             busy,
  input logic [VAL_W-1:0] in_saturation,
  input logic [VAL_W-1:0] in_lightness,
  input logic             out_valid,
  input logic [CH_W-1:0]  out_red,
  input logic [CH_W-1:0]  out_green,
  input logic [CH_W-1:0]  out_blue
);

  a_no_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && rst_n, LATENCY))
    else $error("result without an item taken");

  a_grey: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(in_saturation == '0, LATENCY) |->
      out_red == out_green && out_green == out_blue)
    else $error("zero saturation not grey");

  a_black: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(in_lightness == '0, LATENCY) |->
      out_red == '0 && out_green == '0 && out_blue == '0)
    else $error("zero lightness not black");

  a_white: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(in_lightness >= FULL_SCALE, LATENCY) |->
      out_red == '1 && out_green == '1 && out_blue == '1)
    else $error("full lightness not white");

endmodule

bind hsl_to_rgb_fixed hslrgb_chk u_chk (
  .clk(clk),
  .rst_n(rst_n),
  .start(start),
  .busy(busy),
  .in_saturation(in_saturation),
  .in_lightness(in_lightness),
  .out_valid(out_valid),
  .out_red(out_red),
  .out_green(out_green),
  .out_blue(out_blue)
);
